// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the unfold address generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define ASSERT_DIS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property, checked in every cycle including reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- rtl/core/tuag_pkg.sv -----
// Package: sizes, register indexes and shared types of the unfold address generator.
package tuag_pkg;

   localparam int MAX_DIMS       = 8;
   localparam int EXTENT_BITS    = 4;
   localparam int DIM_W          = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CNT_W          = DIM_W + 1;
   localparam int ROW_FIELD_BITS = 3;
   localparam int ROW_FIELDS     = 8;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_INDEX_W    = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIM_COUNT = 2'd0,
      CSR_ROW_COUNT = 2'd1,
      CSR_EXTENTS   = 2'd2,
      CSR_ROW_ORDER = 2'd3
   } tuag_csr_type;

   typedef struct packed {
      logic [3:0]  dim_count;
      logic [3:0]  row_count;
      logic [31:0] extents_minus_one;
      logic [23:0] row_order;
   } tuag_cfg_type;

   // Traversal plan, per permuted position: bound minus one and offset step
   // taken when that position is the one that increments.
   typedef struct packed {
      logic [CNT_W-1:0]                      used_dims;
      logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  bound_m1;
      logic [MAX_DIMS-1:0][31:0]             delta;
   } tuag_plan_type;

endpackage

// ----- rtl/core/tuag_derive.sv -----
// Plan sequencer: permuted order, strides and per-position offset steps.
module tuag_derive (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  tuag_pkg::tuag_cfg_type cfg,
   output logic                   busy,
   output tuag_pkg::tuag_plan_type plan
);
   import tuag_pkg::*;

   typedef enum logic [1:0] {PH_ROWS, PH_REST, PH_DELTA, PH_IDLE} phase_type;

   phase_type                           phase_ff;
   logic [DIM_W-1:0]                    step_ff;
   logic [CNT_W-1:0]                    pos_ff;
   logic [MAX_DIMS-1:0]                 taken_ff;
   logic [MAX_DIMS-1:0][DIM_W-1:0]      perm_ff;
   logic [MAX_DIMS-1:0][31:0]           stride_ff;
   logic [31:0]                         run_ff;
   logic [31:0]                         acc_ff;
   tuag_plan_type                       plan_ff;

   logic [CNT_W-1:0]        dims;
   logic [CNT_W-1:0]        rows;
   logic [ROW_FIELD_BITS-1:0] sel;
   logic [DIM_W-1:0]        sel_ix;
   logic                    row_ok;
   logic                    rest_ok;
   logic                    step_last;
   logic [DIM_W-1:0]        perm_cur;
   logic [31:0]             stride_cur;
   logic [EXTENT_BITS-1:0]  bound_cur;
   logic [EXTENT_BITS-1:0]  ext_step;
   logic [31:0]             run_in;
   logic [31:0]             acc_in;

   // Extent field k minus one; fields beyond the register mean extent one.
   function automatic logic [EXTENT_BITS-1:0] ext_m1(input logic [31:0] ext,
                                                      input int unsigned k);
      int unsigned sh;
      sh = k * EXTENT_BITS;
      if (sh >= 32) return '0;
      return EXTENT_BITS'(ext >> sh);
   endfunction

   always_comb begin
      if (cfg.dim_count == 4'd0) begin
         dims = CNT_W'(1);
      end else if (32'(cfg.dim_count) > 32'(MAX_DIMS)) begin
         dims = CNT_W'(MAX_DIMS);
      end else begin
         dims = CNT_W'(cfg.dim_count);
      end
      if (32'(cfg.row_count) > 32'(dims)) begin
         rows = dims;
      end else begin
         rows = CNT_W'(cfg.row_count);
      end
      if (32'(rows) > 32'(ROW_FIELDS)) begin
         rows = CNT_W'(ROW_FIELDS);
      end
      sel       = ROW_FIELD_BITS'(cfg.row_order >> (ROW_FIELD_BITS * 32'(step_ff)));
      sel_ix    = DIM_W'(sel);
      row_ok    = (32'(step_ff) < 32'(rows)) && (32'(sel) < 32'(dims))
                  && !taken_ff[sel_ix];
      rest_ok   = (32'(step_ff) < 32'(dims)) && !taken_ff[step_ff];
      step_last = (step_ff == DIM_W'(MAX_DIMS - 1));
      ext_step  = ext_m1(cfg.extents_minus_one, 32'(step_ff));
      run_in    = 32'(run_ff * (32'(ext_step) + 32'd1));
      perm_cur  = perm_ff[step_ff];
      stride_cur = stride_ff[perm_cur];
      bound_cur = ext_m1(cfg.extents_minus_one, 32'(perm_cur));
      acc_in    = acc_ff + 32'(stride_cur * 32'(bound_cur));
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         phase_ff <= PH_ROWS;
         step_ff  <= '0;
         pos_ff   <= '0;
         taken_ff <= '0;
         perm_ff  <= '0;
         run_ff   <= 32'd1;
         acc_ff   <= '0;
      end else begin
         case (phase_ff)
            PH_ROWS: begin
               // strides build up alongside the row list
               stride_ff[step_ff] <= run_ff;
               run_ff             <= run_in;
               if (row_ok) begin
                  taken_ff[sel_ix]             <= 1'b1;
                  perm_ff[pos_ff[DIM_W-1:0]]   <= sel_ix;
                  pos_ff                       <= pos_ff + CNT_W'(1);
               end
               step_ff <= step_ff + DIM_W'(1);
               if (step_last) begin
                  phase_ff <= PH_REST;
                  step_ff  <= '0;
               end
            end
            PH_REST: begin
               if (rest_ok) begin
                  perm_ff[pos_ff[DIM_W-1:0]] <= step_ff;
                  pos_ff                     <= pos_ff + CNT_W'(1);
               end
               step_ff <= step_ff + DIM_W'(1);
               if (step_last) begin
                  phase_ff <= PH_DELTA;
                  step_ff  <= '0;
               end
            end
            PH_DELTA: begin
               // step = own stride minus the span wound back on lower positions
               plan_ff.delta[step_ff]    <= stride_cur - acc_ff;
               plan_ff.bound_m1[step_ff] <= bound_cur;
               plan_ff.used_dims         <= dims;
               acc_ff                    <= acc_in;
               step_ff                   <= step_ff + DIM_W'(1);
               if (step_last) begin
                  phase_ff <= PH_IDLE;
                  step_ff  <= '0;
               end
            end
            PH_IDLE: begin
               phase_ff <= PH_IDLE;
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign busy = (phase_ff != PH_IDLE);
   assign plan = plan_ff;

endmodule

// ----- rtl/core/tensor_unfold_address_gen_unit.sv -----
// Top level: gather-address generator for tensor matricization (unfolding).
//
// Each request item yields one response item: the column-major source offset of the next
// element of the unfolded tensor, its linear destination index and a flag on the final
// element, after which the count wraps to zero. Setting req_restart starts the item at
// element zero. Registers are written through the csr_ port (index 0 dim_count, 1 row_count,
// 2 extents_minus_one, 3 row_order); every write, and reset, clears the count and starts a
// plan pass that holds req_ready low while the permuted order, strides and per-digit offset
// steps are rebuilt, one position per cycle. After that one item is taken every cycle while
// the skid stage is empty: the offset is updated incrementally by a single 32-bit add of the
// step of the digit that increments, selected by a priority scan of the digits. Results sit
// in an output register backed by a one-item skid stage: while a result waits the request
// side takes one more item, and a full skid stage then holds req_ready low until the
// waiting item leaves; an accepted item goes straight into the output register when it is free.
module tensor_unfold_address_gen_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tuag_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tuag_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    rsp_src_offset,
   output logic [31:0]                    rsp_dst_index,
   output logic                           rsp_last
);
   import tuag_pkg::*;
   `include "assert_macros.svh"

   tuag_cfg_type                          cfg_ff;
   tuag_plan_type                         plan;
   logic                                  busy;

   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  digit_ff;
   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  digit_in;
   logic [31:0]                           offset_ff;
   logic [31:0]                           offset_in;
   logic [31:0]                           dest_ff;
   logic [31:0]                           dest_in;

   logic                                  out_valid_ff;
   logic [31:0]                           out_offset_ff;
   logic [31:0]                           out_dest_ff;
   logic                                  out_last_ff;
   logic                                  skid_valid_ff;
   logic [31:0]                           skid_offset_ff;
   logic [31:0]                           skid_dest_ff;
   logic                                  skid_last_ff;

   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  eff_digit;
   logic [MAX_DIMS-1:0]                   at_max;
   logic [DIM_W-1:0]                      carry_pos;
   logic [31:0]                           eff_offset;
   logic [31:0]                           eff_dest;
   logic                                  item_last;
   logic                                  accept;
   logic                                  take;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_count         <= 4'd1;
         cfg_ff.row_count         <= '0;
         cfg_ff.extents_minus_one <= '0;
         cfg_ff.row_order         <= '0;
      end else if (csr_we) begin
         case (tuag_csr_type'(csr_index))
            CSR_DIM_COUNT: cfg_ff.dim_count         <= csr_wdata[3:0];
            CSR_ROW_COUNT: cfg_ff.row_count         <= csr_wdata[3:0];
            CSR_EXTENTS:   cfg_ff.extents_minus_one <= csr_wdata[31:0];
            CSR_ROW_ORDER: cfg_ff.row_order         <= csr_wdata[23:0];
            default:       cfg_ff                   <= cfg_ff;
         endcase
      end
   end

   // Rebuild the plan after reset and after every register write.
   tuag_derive u_derive (
      .clock (clock),
      .reset (reset),
      .start (csr_we),
      .cfg   (cfg_ff),
      .busy  (busy),
      .plan  (plan)
   );

   // ---------------------------------------------------------------- step logic
   assign accept = req_valid && req_ready;
   assign take   = out_valid_ff && rsp_ready;

   always_comb begin
      eff_offset = req_restart ? '0 : offset_ff;
      eff_dest   = req_restart ? '0 : dest_ff;
      for (int j = 0; j < MAX_DIMS; j++) begin
         eff_digit[j] = req_restart ? '0 : digit_ff[j];
         // positions beyond the used dimensions count as wound up
         at_max[j] = (j >= 32'(plan.used_dims)) || (eff_digit[j] == plan.bound_m1[j]);
      end
      item_last = &at_max;
      // lowest position not yet at its bound increments; all below it wrap
      carry_pos = '0;
      for (int j = MAX_DIMS - 1; j >= 0; j--) begin
         if (!at_max[j]) carry_pos = DIM_W'(j);
      end
      for (int j = 0; j < MAX_DIMS; j++) begin
         if (item_last || (DIM_W'(j) < carry_pos)) begin
            digit_in[j] = '0;
         end else if (DIM_W'(j) == carry_pos) begin
            digit_in[j] = eff_digit[j] + EXTENT_BITS'(1);
         end else begin
            digit_in[j] = eff_digit[j];
         end
      end
      offset_in = item_last ? '0 : eff_offset + plan.delta[carry_pos];
      dest_in   = item_last ? '0 : eff_dest + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         digit_ff  <= '0;
         offset_ff <= '0;
         dest_ff   <= '0;
      end else if (accept) begin
         digit_ff  <= digit_in;
         offset_ff <= offset_in;
         dest_ff   <= dest_in;
      end
   end

   // ---------------------------------------------------------------- output + skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            // refill the output from the skid stage once the waiting item leaves
            if (take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept && (take || !out_valid_ff)) begin
            out_valid_ff <= 1'b1;
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end else if (take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && take) begin
         out_offset_ff <= skid_offset_ff;
         out_dest_ff   <= skid_dest_ff;
         out_last_ff   <= skid_last_ff;
      end else if (accept && (take || !out_valid_ff)) begin
         out_offset_ff <= eff_offset;
         out_dest_ff   <= eff_dest;
         out_last_ff   <= item_last;
      end
      if (accept && out_valid_ff && !take) begin
         skid_offset_ff <= eff_offset;
         skid_dest_ff   <= eff_dest;
         skid_last_ff   <= item_last;
      end
   end

   // hold off requests while the plan is rebuilt or the skid stage is full
   assign req_ready      = !busy && !skid_valid_ff;
   assign rsp_valid      = out_valid_ff;
   assign rsp_src_offset = out_offset_ff;
   assign rsp_dst_index  = out_dest_ff;
   assign rsp_last       = out_last_ff;

   // ---------------------------------------------------------------- assertions
   `ASSERT_ALWAYS(a_skid_behind_out, clock, skid_valid_ff |-> out_valid_ff)
   `ASSERT_DIS(a_csr_blocks_items, clock, reset, csr_we |=> !req_ready)
   `ASSERT_DIS(a_last_wraps, clock, reset, (accept && item_last) |=> (digit_ff == '0 && dest_ff == '0 && offset_ff == '0))
   `ASSERT_DIS(a_first_offset_zero, clock, reset, (rsp_valid && rsp_dst_index == 32'd0) |-> (rsp_src_offset == 32'd0))

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the tensor unfold gather-address generator.
module tb;
   import tuag_pkg::*;

   // One expected response item: source offset, destination index, final flag.
   typedef struct {
      logic [31:0] src_offset;
      logic [31:0] dst_index;
      logic        last;
   } gather_addr_type;

   // Tracks the unfolding counter alongside the block and holds the addresses still owed.
   class unfold_tracker;
      tuag_cfg_type        regs;
      int unsigned         used_dims;
      int unsigned         dim_order [MAX_DIMS];
      int unsigned         dim_extent[MAX_DIMS];
      logic [31:0]         col_stride[MAX_DIMS];
      int unsigned         digits    [MAX_DIMS];
      logic [31:0]         dest_next;
      gather_addr_type     owed[$];
      int unsigned         errors, checked, finals, restarts, settings;

      function new();
         regs = '0;
         regs.dim_count = 4'd1;
         errors = 0; checked = 0; finals = 0; restarts = 0; settings = 0;
         rebuild_plan();
      endfunction

      function int unsigned extent_of(int unsigned k);
         return int'(regs.extents_minus_one[k*EXTENT_BITS +: EXTENT_BITS]) + 1;
      endfunction

      function void clear_count();
         foreach (digits[k]) digits[k] = 0;
         dest_next = '0;
      endfunction

      // Row dimensions first (bad or repeated entries dropped), then the rest ascending.
      function void rebuild_plan();
         bit          taken[MAX_DIMS];
         int unsigned d, rows, pos, sel;
         d = regs.dim_count;
         if (d == 0) d = 1;
         if (d > MAX_DIMS) d = MAX_DIMS;
         used_dims = d;
         rows = regs.row_count;
         if (rows > d) rows = d;
         if (rows > ROW_FIELDS) rows = ROW_FIELDS;
         foreach (taken[k]) begin
            taken[k] = 1'b0;
            dim_order[k] = 0;
         end
         pos = 0;
         for (int unsigned j = 0; j < rows; j++) begin
            sel = regs.row_order[j*ROW_FIELD_BITS +: ROW_FIELD_BITS];
            if (sel < d && !taken[sel]) begin
               taken[sel] = 1'b1;
               dim_order[pos] = sel;
               pos++;
            end
         end
         for (int unsigned k = 0; k < d; k++) begin
            if (!taken[k]) begin
               dim_order[pos] = k;
               pos++;
            end
         end
         col_stride[0] = 32'd1;
         for (int unsigned k = 1; k < MAX_DIMS; k++)
            col_stride[k] = col_stride[k-1] * extent_of(k-1);
         foreach (dim_extent[k]) dim_extent[k] = extent_of(dim_order[k]);
         clear_count();
      endfunction

      function void apply_reg(tuag_csr_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DIM_COUNT: regs.dim_count         = data[3:0];
            CSR_ROW_COUNT: regs.row_count         = data[3:0];
            CSR_EXTENTS:   regs.extents_minus_one = data[31:0];
            CSR_ROW_ORDER: regs.row_order         = data[23:0];
            default: ;
         endcase
         settings++;
         rebuild_plan();
      endfunction

      function int unsigned owed_count();
         return owed.size();
      endfunction

      // Work out the address of the current element, then step the counter.
      function void note_request(bit restart);
         gather_addr_type e;
         logic [31:0]     sum;
         bit              fin;
         if (restart) begin
            clear_count();
            restarts++;
         end
         sum = '0;
         fin = 1'b1;
         for (int unsigned j = 0; j < used_dims; j++) begin
            sum += digits[j] * col_stride[dim_order[j]];
            if (digits[j] != dim_extent[j] - 1) fin = 1'b0;
         end
         e.src_offset = sum;
         e.dst_index  = dest_next;
         e.last       = fin;
         owed.push_back(e);
         if (fin) begin
            clear_count();
         end else begin
            for (int unsigned j = 0; j < used_dims; j++) begin
               digits[j]++;
               if (digits[j] >= dim_extent[j]) digits[j] = 0;
               else break;
            end
            dest_next++;
         end
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_response(logic [31:0] src, logic [31:0] dst, logic fin);
         gather_addr_type e;
         if (owed.size() == 0) begin
            report($sformatf("response with nothing owed (src %0h dst %0d)", src, dst));
         end else begin
            e = owed.pop_front();
            checked++;
            if (e.last) finals++;
            if (src !== e.src_offset)
               report($sformatf("dst %0d: src_offset %0h, want %0h", e.dst_index, src,
                                e.src_offset));
            if (dst !== e.dst_index)
               report($sformatf("dst_index %0d, want %0d", dst, e.dst_index));
            if (fin !== e.last)
               report($sformatf("dst %0d: last %0b, want %0b", e.dst_index, fin, e.last));
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_restart;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [31:0]            rsp_src_offset;
   logic [31:0]            rsp_dst_index;
   logic                   rsp_last;

   unfold_tracker tracker = new();
   bit            idle_on;
   int unsigned   items_sent;

   tensor_unfold_address_gen_unit uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_src_offset (rsp_src_offset),
      .rsp_dst_index  (rsp_dst_index),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit: far beyond the slowest legal run, plan passes included.
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // Sample every handshake and register write on the rising edge, before outputs move.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            tracker.apply_reg(tuag_csr_type'(csr_index), csr_wdata);
         if (req_valid && req_ready)
            tracker.note_request(req_restart);
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_src_offset, rsp_dst_index, rsp_last);
      end
   end

   // Gap length: mostly none, some short, a few long; none at all when idling is off.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Stall the response side at random, on its own schedule.
   initial begin
      int unsigned stall_left;
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            rsp_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // Present one request item, keep valid up, and hold until it is taken.
   task automatic push_request(bit restart, int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Drop valid and wait until every owed address has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.owed_count() > 0) @(posedge clock);
   endtask

   // Write one register, then wait out the plan pass the write starts.
   task automatic write_reg(tuag_csr_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      while (req_ready) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Fill the unused upper bits of the narrow registers with noise; the block must drop them.
   task automatic load_setting(logic [3:0] dims, logic [3:0] rows, logic [31:0] ext,
                               logic [23:0] order);
      write_reg(CSR_DIM_COUNT, {28'($urandom), dims});
      write_reg(CSR_ROW_COUNT, {28'($urandom), rows});
      write_reg(CSR_EXTENTS,   ext);
      write_reg(CSR_ROW_ORDER, {8'($urandom), order});
   endtask

   initial begin
      logic [23:0] rev_order;
      logic [31:0] ext;
      logic [3:0]  dims;
      int unsigned n;

      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = CSR_DIM_COUNT;
      csr_wdata   = '0;
      req_valid   = 1'b0;
      req_restart = 1'b0;
      idle_on     = 1'b1;
      items_sent  = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      // let the plan pass after reset finish
      do @(posedge clock); while (!req_ready);

      // Reset setting: one dimension of extent one, so every item is the final one.
      push_request(1'b0, 0);
      push_request(1'b1, 0);
      push_request(1'b0, 1);
      drain();

      // Widest tensor: all eight dimensions at extent sixteen, rows in reverse order.
      for (int j = 0; j < ROW_FIELDS; j++) rev_order[3*j +: 3] = 3'(7 - j);
      load_setting(4'd8, 4'd8, 32'hffff_ffff, rev_order);
      push_request(1'b0, 0);
      push_request(1'b0, 0);
      push_request(1'b1, 0);
      push_request(1'b0, 0);
      drain();

      // Zero dimensions (taken as one), oversized row count, row entries out of range.
      load_setting(4'd0, 4'd15, 32'h0000_0003, 24'hff_ffff);
      for (int i = 0; i < 6; i++) push_request(1'b0, 0);
      drain();

      // Saturated dimension count, repeated row entry, restart in mid count.
      load_setting(4'd15, 4'd3, 32'h0000_0011, {15'd0, 3'd1, 3'd2, 3'd2});
      push_request(1'b0, 0);
      push_request(1'b0, 0);
      push_request(1'b1, 0);
      push_request(1'b0, 0);
      push_request(1'b0, 0);
      push_request(1'b0, 0);
      drain();

      // Random settings; most tensors small enough to wrap several times within a phase.
      for (int phase = 0; items_sent < 470; phase++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         n = $urandom_range(0, 9);
         if (n == 0) dims = 4'd0;
         else if (n == 1) dims = 4'($urandom_range(9, 15));
         else dims = 4'($urandom_range(1, 8));
         if ($urandom_range(0, 9) < 7) begin
            for (int k = 0; k < MAX_DIMS; k++)
               ext[4*k +: 4] = ($urandom_range(0, 2) == 0) ? 4'd1 : 4'd0;
            ext[4*$urandom_range(0, 7) +: 4] = 4'($urandom_range(0, 7));
         end else begin
            ext = $urandom;
         end
         load_setting(dims, 4'($urandom_range(0, 15)), ext, 24'($urandom));
         n = $urandom_range(30, 70);
         for (int i = 0; i < n; i++) begin
            // hold the sender until every owed result is back, mid-phase
            if (i == n / 2 && (phase == 0 || $urandom_range(0, 3) == 0))
               drain();
            push_request($urandom_range(0, 9) == 0, pick_gap());
         end
         drain();
      end

      // Leave room for any stray response after the last owed one.
      repeat (8) @(posedge clock);
      if (tracker.owed_count() != 0)
         tracker.report($sformatf("%0d addresses never returned", tracker.owed_count()));
      $display("covered %0d items over %0d register writes, %0d final elements, %0d restarts",
               items_sent, tracker.settings, tracker.finals, tracker.restarts);
      $display("settings included wide, saturated and malformed row lists; %0d mismatches",
               tracker.errors);
      if (tracker.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
